### hw/rtl/svr_pkg.sv
// ----------------------------------------------------------------------------
// svr_pkg
// Shared types and constants for the two-wheel stepper speed ramp.
// ----------------------------------------------------------------------------
`default_nettype none

package svr_pkg;

  // width of the period numerator register and of the divider quotient
  localparam int NUM_WIDTH = 32;

  // register reset values
  localparam logic [31:0] ACCEL_RESET = 32'd256;
  localparam logic [31:0] NUMER_RESET = 32'd3015929;

  // register indexes on the config port
  localparam logic REG_ACCEL = 1'b0;
  localparam logic REG_NUMER = 1'b1;

  // control from the sequencer to one wheel lane
  typedef struct packed {
    logic start;  // take a transaction this cycle
    logic load;   // load targets instead of ramping
  } lane_ctl_t;

  // status from one wheel lane
  typedef struct packed {
    logic busy;   // ramp or period division in progress
    logic done;   // one-cycle pulse, results stable until next start
  } lane_sts_t;

endpackage

`default_nettype wire

### hw/rtl/svr_div.sv
// ----------------------------------------------------------------------------
// svr_div
// Restoring radix-2 divider: one quotient bit per cycle, flags zero divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module svr_div #(
  parameter int SPEED_WIDTH = 24
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic [svr_pkg::NUM_WIDTH-1:0]  numer,
  input  wire logic [SPEED_WIDTH-1:0]         divisor,
  output logic                                done,
  output logic                                div_zero,
  output logic [svr_pkg::NUM_WIDTH-1:0]       quotient
);

  localparam int NW   = svr_pkg::NUM_WIDTH;
  localparam int CntW = $clog2(NW + 1);

  logic                   busy;
  logic [CntW-1:0]        cnt;
  logic [SPEED_WIDTH-1:0] rem;
  logic [SPEED_WIDTH-1:0] dvs;
  logic [NW-1:0]          qr;

  logic [SPEED_WIDTH+1:0] trial;
  logic [SPEED_WIDTH:0]   shifted;
  logic                   ge;

  // trial subtract of the divisor from the shifted partial remainder
  always_comb begin
    shifted = {rem, qr[NW-1]};
    trial   = {1'b0, shifted} - {2'b00, dvs};
    ge      = ~trial[SPEED_WIDTH+1];
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CntW'(NW);
      end else if (busy) begin
        cnt <= cnt - CntW'(1);
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      qr       <= numer;
      div_zero <= (divisor == '0);
    end else if (busy) begin
      rem <= ge ? trial[SPEED_WIDTH-1:0] : shifted[SPEED_WIDTH-1:0];
      qr  <= {qr[NW-2:0], ge};
    end
  end

  assign quotient = qr;

endmodule

`default_nettype wire

### hw/rtl/svr_lane.sv
// ----------------------------------------------------------------------------
// svr_lane
// One wheel: target and current speed, ramp step and step period.
// ----------------------------------------------------------------------------
`default_nettype none

module svr_lane #(
  parameter int SPEED_WIDTH  = 24,
  parameter int PERIOD_WIDTH = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire svr_pkg::lane_ctl_t             ctl,
  input  wire logic [SPEED_WIDTH-1:0]         target_in,
  input  wire logic [SPEED_WIDTH-2:0]         accel,
  input  wire logic [svr_pkg::NUM_WIDTH-1:0]  numer,
  output svr_pkg::lane_sts_t                  sts,
  output logic                                neg,
  output logic [PERIOD_WIDTH-1:0]             reload,
  output logic [PERIOD_WIDTH-2:0]             compare,
  output logic [SPEED_WIDTH-1:0]              speed
);

  localparam int NW = svr_pkg::NUM_WIDTH;
  localparam logic [NW-1:0] PerMaxW = NW'((64'd1 << PERIOD_WIDTH) - 64'd1);

  typedef enum logic [2:0] {
    L_IDLE  = 3'b001,
    L_ISSUE = 3'b010,
    L_WAIT  = 3'b100
  } lane_state_t;

  lane_state_t             state;
  logic [SPEED_WIDTH-1:0]  current;
  logic [SPEED_WIDTH-1:0]  target;
  logic [SPEED_WIDTH-1:0]  current_next;
  logic [PERIOD_WIDTH-1:0] period;
  logic [PERIOD_WIDTH-1:0] period_next;
  logic                    done;

  logic [SPEED_WIDTH:0]    diff;
  logic [SPEED_WIDTH:0]    gap;
  logic [SPEED_WIDTH:0]    acc_ext;
  logic [SPEED_WIDTH-1:0]  mag;

  logic                    div_start;
  logic                    div_done;
  logic                    div_zero;
  logic [NW-1:0]           quotient;

  // ramp one step toward the target, snap when the gap is below the step
  always_comb begin
    diff    = {current[SPEED_WIDTH-1], current} - {target[SPEED_WIDTH-1], target};
    gap     = diff[SPEED_WIDTH] ? (~diff + (SPEED_WIDTH+1)'(1)) : diff;
    acc_ext = {2'b00, accel};
    priority if (gap < acc_ext) begin
      current_next = target;
    end else if (diff[SPEED_WIDTH]) begin
      current_next = current + {1'b0, accel};
    end else if (diff != '0) begin
      current_next = current - {1'b0, accel};
    end else begin
      current_next = current;
    end
  end

  // speed magnitude for the divider
  assign mag = current[SPEED_WIDTH-1] ? (~current + SPEED_WIDTH'(1)) : current;

  // saturate the quotient into the period range
  always_comb begin
    priority if (div_zero || (quotient > PerMaxW)) begin
      period_next = '1;
    end else if (quotient == '0) begin
      period_next = PERIOD_WIDTH'(1);
    end else begin
      period_next = quotient[PERIOD_WIDTH-1:0];
    end
  end

  assign div_start = (state == L_ISSUE);

  svr_div #(
    .SPEED_WIDTH (SPEED_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .numer    (numer),
    .divisor  (mag),
    .done     (div_done),
    .div_zero (div_zero),
    .quotient (quotient)
  );

  // lane sequencer and speed state
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= L_IDLE;
      current <= '0;
      target  <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        L_IDLE: begin
          if (ctl.start) begin
            if (ctl.load) begin
              target <= target_in;
            end else begin
              current <= current_next;
            end
            state <= L_ISSUE;
          end
        end
        L_ISSUE: begin
          state <= L_WAIT;
        end
        L_WAIT: begin
          if (div_done) begin
            state <= L_IDLE;
            done  <= 1'b1;
          end
        end
        default: begin
          state <= L_IDLE;
        end
      endcase
    end
  end

  // period register
  always_ff @(posedge clk) begin
    if (div_done) begin
      period <= period_next;
    end
  end

  assign sts.busy = (state != L_IDLE);
  assign sts.done = done;
  assign neg      = current[SPEED_WIDTH-1];
  assign speed    = current;
  assign reload   = period - PERIOD_WIDTH'(1);
  assign compare  = period[PERIOD_WIDTH-1:1];

endmodule

`default_nettype wire

### hw/rtl/stepper_velocity_ramp_period.sv
// ----------------------------------------------------------------------------
// stepper_velocity_ramp_period
// Two-wheel stepper speed ramp with step timer reload and compare values.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): mode 0 loads new signed target
//   speeds, mode 1 is a ramp tick that moves each current speed at most one
//   accel_step toward its target. Every input transaction yields exactly
//   one output transaction (out_valid / out_stall) with direction bits,
//   timer reload (period - 1), compare (period / 2) and current speeds.
//   One transaction is in work at a time, so a new one is taken only after
//   the previous result has entered the output register. Each wheel lane
//   has its own radix-2 period divider, and both run side by side.
//   A finished result sits in the output register while the next input is
//   taken; if the receiver still stalls when the next result is ready, the
//   block holds that result and stalls its input until the register frees.
//   Registers (APB, 0x0 accel_step, 0x4 period_numerator) must be written
//   only while idle; the block itself does not enforce this. Reset clears
//   all speeds and targets to zero, sets accel_step to 256 and
//   period_numerator to 3015929, and empties the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module stepper_velocity_ramp_period #(
  parameter int SPEED_WIDTH  = 24,
  parameter int PERIOD_WIDTH = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  // config port
  input  wire logic                    psel,
  input  wire logic                    penable,
  input  wire logic                    pwrite,
  input  wire logic [2:0]              paddr,
  input  wire logic [31:0]             pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  // input channel
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic                    mode,
  input  wire logic [SPEED_WIDTH-1:0]  target_left,
  input  wire logic [SPEED_WIDTH-1:0]  target_right,
  // output channel
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic                         dir_left,
  output logic                         dir_right,
  output logic [PERIOD_WIDTH-1:0]      reload_left,
  output logic [PERIOD_WIDTH-2:0]      compare_left,
  output logic [PERIOD_WIDTH-1:0]      reload_right,
  output logic [PERIOD_WIDTH-2:0]      compare_right,
  output logic [SPEED_WIDTH-1:0]       speed_left,
  output logic [SPEED_WIDTH-1:0]       speed_right
);

  localparam int NW = svr_pkg::NUM_WIDTH;

  typedef enum logic [2:0] {
    T_IDLE = 3'b001,
    T_BUSY = 3'b010,
    T_HOLD = 3'b100
  } top_state_t;

  top_state_t          state;
  logic [SPEED_WIDTH-2:0] accel;
  logic [NW-1:0]       numer;
  logic                cfg_wr;
  logic                in_take;
  logic                out_free;
  logic                res_ready;

  svr_pkg::lane_ctl_t  ctl;
  svr_pkg::lane_sts_t  sts_l;
  svr_pkg::lane_sts_t  sts_r;

  logic                    neg_l, neg_r;
  logic [PERIOD_WIDTH-1:0] rel_l, rel_r;
  logic [PERIOD_WIDTH-2:0] cmp_l, cmp_r;
  logic [SPEED_WIDTH-1:0]  spd_l, spd_r;

  // config registers
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      accel <= (SPEED_WIDTH-1)'(svr_pkg::ACCEL_RESET);
      numer <= svr_pkg::NUMER_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        svr_pkg::REG_ACCEL: accel <= pwdata[SPEED_WIDTH-2:0];
        svr_pkg::REG_NUMER: numer <= pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      svr_pkg::REG_ACCEL: prdata = 32'(accel);
      svr_pkg::REG_NUMER: prdata = numer;
      default:            prdata = '0;
    endcase
  end

  // input handshake
  assign in_stall  = (state != T_IDLE);
  assign in_take   = in_valid & ~in_stall;
  assign ctl.start = in_take;
  assign ctl.load  = ~mode;

  // wheel lanes
  svr_lane #(
    .SPEED_WIDTH  (SPEED_WIDTH),
    .PERIOD_WIDTH (PERIOD_WIDTH)
  ) u_lane_left (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .target_in (target_left),
    .accel     (accel),
    .numer     (numer),
    .sts       (sts_l),
    .neg       (neg_l),
    .reload    (rel_l),
    .compare   (cmp_l),
    .speed     (spd_l)
  );

  svr_lane #(
    .SPEED_WIDTH  (SPEED_WIDTH),
    .PERIOD_WIDTH (PERIOD_WIDTH)
  ) u_lane_right (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .target_in (target_right),
    .accel     (accel),
    .numer     (numer),
    .sts       (sts_r),
    .neg       (neg_r),
    .reload    (rel_r),
    .compare   (cmp_r),
    .speed     (spd_r)
  );

  // merge lane results into the output register
  assign out_free  = ~out_valid | ~out_stall;
  assign res_ready = (sts_l.done & sts_r.done) | (state == T_HOLD);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= T_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid & ~out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        T_IDLE: begin
          if (in_take) begin
            state <= T_BUSY;
          end
        end
        T_BUSY, T_HOLD: begin
          if (res_ready) begin
            if (out_free) begin
              out_valid <= 1'b1;
              state     <= T_IDLE;
            end else begin
              state <= T_HOLD;
            end
          end
        end
        default: begin
          state <= T_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state != T_IDLE) && res_ready && out_free) begin
      dir_left      <= ~neg_l;
      dir_right     <= neg_r;
      reload_left   <= rel_l;
      compare_left  <= cmp_l;
      reload_right  <= rel_r;
      compare_right <= cmp_r;
      speed_left    <= spd_l;
      speed_right   <= spd_r;
    end
  end

  // lanes run in lockstep
  assert property (@(posedge clk) disable iff (rst)
    (sts_l.done == sts_r.done) && (sts_l.busy == sts_r.busy))
    else $error("wheel lanes out of step");

  // no transaction is taken while a lane works
  assert property (@(posedge clk) disable iff (rst)
    sts_l.busy |-> in_stall)
    else $error("input taken while lane busy");

  // lane results only arrive while the sequencer waits for them
  assert property (@(posedge clk) disable iff (rst)
    sts_l.done |-> (state == T_BUSY))
    else $error("lane done outside busy state");

  // a new result appears only after lanes finish or from a held result
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(sts_l.done) || $past(state == T_HOLD)))
    else $error("output valid without a finished result");

endmodule

`default_nettype wire
